// File: design/kps_pkg.sv
// Shared types, constants and lookup functions for the keypad scanner.
`timescale 1ns / 1ps
`default_nettype none
package kps_pkg;

    localparam int ROWS       = 5;
    localparam int ROW_W      = 3;
    localparam int KEY_W      = 5;
    localparam int COL_W      = 4;
    localparam int CHAR_W     = 7;
    localparam int DEB_W      = 16;
    localparam int NAME_COUNT = 20;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [COL_W-1:0]  ALL_HIGH    = 4'hF;
    localparam logic [DEB_W-1:0]  DEB_RESET   = 16'd20;
    localparam logic [CHAR_W-1:0] CH_UNKNOWN  = 7'h3F;

    typedef enum logic [1:0] {
        PH_SCAN    = 2'd0,
        PH_PRESS   = 2'd1,
        PH_HOLD    = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef struct packed {
        logic [4:0]        row_lines;
        logic              char_valid;
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
        logic [KEY_W-1:0]  key_index;
    } t_result;

    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_step;

    // Lowest low column wins, except that all four high reads as index 4.
    function automatic logic [2:0] col_index(input logic [COL_W-1:0] cols);
        logic [2:0] idx;
        case (cols)
            4'h1, 4'h5, 4'h9, 4'hD: idx = 3'd1;
            4'h3, 4'hB:             idx = 3'd2;
            4'h7:                   idx = 3'd3;
            4'hF:                   idx = 3'd4;
            default:                idx = 3'd0;
        endcase
        return idx;
    endfunction

    function automatic logic name_is_pair(input logic [KEY_W-1:0] key);
        return (key >= 5'd16) && (key <= 5'd19);
    endfunction

    function automatic logic [CHAR_W-1:0] name_first(input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] ch;
        if (key <= 5'd9)                    ch = 7'(7'h30 + 7'(key));
        else if (key <= 5'd15)              ch = 7'(7'h41 + 7'(key - 5'd10));
        else if (key <= 5'd18)              ch = 7'h46;
        else if (key == 5'd19)              ch = 7'h43;
        else                                ch = CH_UNKNOWN;
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] name_second(input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] ch;
        if (key == 5'd19) ch = 7'h52;
        else              ch = 7'(7'h31 + 7'(key - 5'd16));
        return ch;
    endfunction

endpackage
`default_nettype wire

// File: design/kps_core.sv
// Scan/debounce state machine: state update and result forming per column sample.
`timescale 1ns / 1ps
`default_nettype none
module kps_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [kps_pkg::COL_W-1:0]  i_cols,
    input  wire logic [kps_pkg::DEB_W-1:0]  i_debounce,
    output kps_pkg::t_step                  o_step
);
    import kps_pkg::*;

    t_phase             r_phase, n_phase;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [DEB_W-1:0]   r_wait, n_wait;
    logic [KEY_W-1:0]   r_held, n_held;

    logic               all_high;
    logic               wait_more;
    logic [ROW_W:0]     row_inc;
    logic [ROW_W-1:0]   row_adv;
    logic               emit;
    logic [4:0]         pattern;

    assign all_high  = (i_cols == ALL_HIGH);
    assign wait_more = (r_wait > DEB_W'(1));
    assign row_inc   = {1'b0, r_row} + (ROW_W+1)'(1);
    assign row_adv   = (row_inc >= (ROW_W+1)'(ROWS)) ? '0 : row_inc[ROW_W-1:0];
    assign emit      = (r_phase == PH_RELEASE) && !wait_more && all_high;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_row   = r_row;
        n_wait  = r_wait;
        n_held  = r_held;
        unique case (r_phase)
            PH_SCAN: begin
                if (!all_high) begin
                    n_phase = PH_PRESS;
                    n_wait  = i_debounce;
                end else begin
                    n_row = row_adv;
                end
            end
            PH_PRESS: begin
                if (wait_more) begin
                    n_wait = r_wait - DEB_W'(1);
                end else if (all_high) begin
                    n_phase = PH_SCAN;
                    n_row   = '0;
                    n_wait  = '0;
                end else begin
                    n_held  = KEY_W'({r_row, 2'b00} + {2'b00, col_index(i_cols)});
                    n_phase = PH_HOLD;
                    n_wait  = '0;
                end
            end
            PH_HOLD: begin
                if (all_high) begin
                    n_phase = PH_RELEASE;
                    n_wait  = i_debounce;
                end
            end
            PH_RELEASE: begin
                if (wait_more) begin
                    n_wait = r_wait - DEB_W'(1);
                end else if (!all_high) begin
                    n_phase = PH_HOLD;
                    n_wait  = '0;
                end else begin
                    n_phase = PH_SCAN;
                    n_row   = '0;
                    n_wait  = '0;
                end
            end
            default: n_phase = PH_SCAN;
        endcase
    end

    // outputs
    always_comb begin
        pattern = 5'(~(8'b1 << n_row));
        o_step  = '0;
        o_step.r0.row_lines = pattern;
        o_step.r1.row_lines = pattern;
        if (emit) begin
            o_step.two           = name_is_pair(r_held);
            o_step.r0.char_valid = 1'b1;
            o_step.r0.char_code  = name_first(r_held);
            o_step.r0.last_char  = !name_is_pair(r_held);
            o_step.r0.key_index  = r_held;
            o_step.r1.char_valid = 1'b1;
            o_step.r1.char_code  = name_second(r_held);
            o_step.r1.last_char  = 1'b1;
            o_step.r1.key_index  = r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SCAN;
            r_row   <= '0;
            r_wait  <= '0;
            r_held  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_row   <= n_row;
            r_wait  <= n_wait;
            r_held  <= n_held;
        end
    end

endmodule
`default_nettype wire

// File: design/matrix_keypad_scanner.sv
// Top level: keypad scanner with debounce, config register and result queue.
//
//  channel   dir  transfer when                    payload
//  s_axis    in   s_axis_tvalid & s_axis_tready    tdata[3:0] column_sense
//  m_axis    out  m_axis_tvalid & m_axis_tready    tdata row/valid/code/key, tlast
//  cfg       in   i_cfg_valid & o_cfg_ready        i_cfg_data debounce_ticks
//
// One column sample per cycle while s_axis_tready is high; its result
// enters a four-entry output queue in the same cycle, one entry or two for
// a two-character key name. s_axis_tready is high while the queue has room
// for two entries; with a free-running sink, pairs can still stall samples.
// Synchronous active-low reset: scanning at row 0, debounce of 20, queue empty.
// The cfg port is always ready.
`timescale 1ns / 1ps
`default_nettype none
module matrix_keypad_scanner (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [3:0] column_sense, [7:4] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [4:0] row_lines, [5] char_valid, [12:6] char_code, [17:13] key_index, rest zero
    output logic [23:0]      m_axis_tdata,
    output logic             m_axis_tlast,   // last_char
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data      // debounce_ticks
);
    import kps_pkg::*;

    logic [DEB_W-1:0]     r_debounce;
    t_result              r_buf [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_AW:0]     r_count, n_count;

    t_step                step;
    logic                 in_xfer, out_xfer;
    t_result              head;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    kps_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_xfer),
        .i_cols     (s_axis_tdata[COL_W-1:0]),
        .i_debounce (r_debounce),
        .o_step     (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEB_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_debounce <= i_cfg_data;
        end
    end

    always_comb begin
        n_count = r_count;
        if (in_xfer)  n_count = n_count + (step.two ? (FIFO_AW+1)'(2) : (FIFO_AW+1)'(1));
        if (out_xfer) n_count = n_count - (FIFO_AW+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (in_xfer) r_wr <= r_wr + (step.two ? FIFO_AW'(2) : FIFO_AW'(1));
            if (out_xfer) r_rd <= r_rd + FIFO_AW'(1);
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_buf[r_wr] <= step.r0;
            if (step.two) r_buf[r_wr + FIFO_AW'(1)] <= step.r1;
        end
    end

    assign head          = r_buf[r_rd];
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tlast  = head.last_char;
    assign m_axis_tdata  = {6'b0, head.key_index, head.char_code, head.char_valid,
                            head.row_lines};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_room_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> r_count <= (FIFO_AW+1)'(FIFO_DEPTH - 2))
        else $error("sample taken without room for two results");

    a_pair_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && head.char_valid && !head.last_char) |-> r_count >= (FIFO_AW+1)'(2))
        else $error("first character queued without its partner");

    a_idle_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !step.r0.char_valid) |-> !step.two)
        else $error("pair flagged for a result without a character");

endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the keypad scanner: tick-level predictor, stream scoreboard.
`timescale 1ns / 1ps
module testbench;
    import kps_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h0F;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 16'd0;

    matrix_keypad_scanner DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Predicted scanner state
    t_phase            pr_phase = PH_SCAN;
    logic [ROW_W-1:0]  pr_row = '0;
    logic [DEB_W-1:0]  pr_wait = '0;
    logic [KEY_W-1:0]  pr_key = '0;
    logic [DEB_W-1:0]  pr_debounce = DEB_RESET;

    t_result tick_results_due[$];
    int      mismatches = 0;
    int      live_samples = 0;
    bit      src_idle_en = 1'b1;
    bit      sink_idle_en = 1'b1;
    bit      sink_block = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Index of the lowest column reading low; 4 when all read high.
    function automatic logic [2:0] lowest_low_column(input logic [COL_W-1:0] cols);
        int n;
        n = 0;
        while (n < 4 && cols[n]) n++;
        return 3'(n);
    endfunction

    function automatic void key_name(input logic [KEY_W-1:0] key,
                                     output logic [CHAR_W-1:0] first_ch,
                                     output logic [CHAR_W-1:0] second_ch,
                                     output logic two_chars);
        second_ch = '0;
        two_chars = 1'b0;
        if (key <= 5'd9) begin
            first_ch = 7'h30 + 7'(key);
        end else if (key <= 5'd15) begin
            first_ch = 7'h41 + 7'(key - 5'd10);
        end else if (key <= 5'd18) begin
            first_ch  = 7'h46;                       // F1..F3
            second_ch = 7'h31 + 7'(key - 5'd16);
            two_chars = 1'b1;
        end else if (key == 5'd19) begin
            first_ch  = 7'h43;                       // CR
            second_ch = 7'h52;
            two_chars = 1'b1;
        end else begin
            first_ch = 7'h3F;
        end
    endfunction

    // Advance the predicted scanner by one column sample and queue its results.
    function automatic void predict_scan_tick(input logic [COL_W-1:0] cols);
        t_result           rs;
        logic [CHAR_W-1:0] c0;
        logic [CHAR_W-1:0] c1;
        logic              two;
        logic              emit;
        emit = 1'b0;
        case (pr_phase)
            PH_SCAN: begin
                if (cols != ALL_HIGH) begin
                    pr_phase = PH_PRESS;
                    pr_wait  = pr_debounce;
                end else begin
                    pr_row = (pr_row == ROW_W'(ROWS - 1)) ? '0 : pr_row + 1'b1;
                end
            end
            PH_PRESS: begin
                if (pr_wait > 1) begin
                    pr_wait--;
                end else if (cols == ALL_HIGH) begin
                    pr_phase = PH_SCAN;
                    pr_row   = '0;
                    pr_wait  = '0;
                end else begin
                    pr_key   = KEY_W'(pr_row * 4 + lowest_low_column(cols));
                    pr_phase = PH_HOLD;
                    pr_wait  = '0;
                end
            end
            PH_HOLD: begin
                if (cols == ALL_HIGH) begin
                    pr_phase = PH_RELEASE;
                    pr_wait  = pr_debounce;
                end
            end
            default: begin
                if (pr_wait > 1) begin
                    pr_wait--;
                end else if (cols != ALL_HIGH) begin
                    pr_phase = PH_HOLD;
                    pr_wait  = '0;
                end else begin
                    pr_phase = PH_SCAN;
                    pr_row   = '0;
                    pr_wait  = '0;
                    emit     = 1'b1;
                end
            end
        endcase
        rs.row_lines  = ~(5'd1 << pr_row);
        rs.char_valid = 1'b0;
        rs.char_code  = '0;
        rs.last_char  = 1'b0;
        rs.key_index  = '0;
        if (emit) begin
            key_name(pr_key, c0, c1, two);
            rs.char_valid = 1'b1;
            rs.char_code  = c0;
            rs.last_char  = !two;
            rs.key_index  = pr_key;
            tick_results_due.push_back(rs);
            if (two) begin
                rs.char_code = c1;
                rs.last_char = 1'b1;
                tick_results_due.push_back(rs);
            end
        end else begin
            tick_results_due.push_back(rs);
        end
    endfunction

    // Random column pattern whose lowest low column is col.
    function automatic logic [COL_W-1:0] column_pattern(input logic [1:0] col);
        logic [COL_W-1:0] p;
        p = 4'($urandom_range(15));
        for (int b = 0; b < 4; b++) if (b < col) p[b] = 1'b1;
        p[col] = 1'b0;
        return p;
    endfunction

    task automatic note_mismatch(input string field, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0h, got %0h at %0t", field, want, got, $time);
    endtask

    // Result side: check each transfer, then pick tready for the next cycle.
    always @(posedge i_clk) begin : result_side
        t_result want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (tick_results_due.size() == 0) begin
                note_mismatch("unexpected result", 0, m_axis_tdata);
            end else begin
                want = tick_results_due.pop_front();
                if (m_axis_tdata[4:0] !== want.row_lines)
                    note_mismatch("row_lines", want.row_lines, m_axis_tdata[4:0]);
                if (m_axis_tdata[5] !== want.char_valid)
                    note_mismatch("char_valid", want.char_valid, m_axis_tdata[5]);
                if (m_axis_tdata[12:6] !== want.char_code)
                    note_mismatch("char_code", want.char_code, m_axis_tdata[12:6]);
                if (m_axis_tdata[17:13] !== want.key_index)
                    note_mismatch("key_index", want.key_index, m_axis_tdata[17:13]);
                if (m_axis_tlast !== want.last_char)
                    note_mismatch("last_char", want.last_char, m_axis_tlast);
            end
        end
        m_axis_tready <= !sink_block && !(sink_idle_en && $urandom_range(99) < 28);
    end

    task automatic hold_off_sink(input int cycles);
        sink_block <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        sink_block <= 1'b0;
    endtask

    task automatic send_sample(input logic [COL_W-1:0] cols);
        bit ignored;
        while (src_idle_en && $urandom_range(99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, cols};
        do @(posedge i_clk); while (!s_axis_tready);
        ignored = (pr_phase == PH_PRESS || pr_phase == PH_RELEASE) && pr_wait > 1;
        predict_scan_tick(cols);
        if (!ignored) live_samples++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (tick_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_debounce(input logic [DEB_W-1:0] ticks);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ticks;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pr_debounce = ticks;
    endtask

    // Feed noise until the press or release wait reaches its recheck.
    task automatic sit_out_wait();
        while ((pr_phase == PH_PRESS || pr_phase == PH_RELEASE) && pr_wait > 1)
            send_sample(4'($urandom_range(15)));
    endtask

    task automatic return_to_scan();
        while (pr_phase != PH_SCAN) begin
            sit_out_wait();
            send_sample(ALL_HIGH);
        end
    endtask

    task automatic press_key(input logic [KEY_W-1:0] key, input int bounce_pct);
        return_to_scan();
        while (pr_row != key[4:2]) send_sample(ALL_HIGH);
        send_sample(column_pattern(key[1:0]));
        sit_out_wait();
        if ($urandom_range(99) < bounce_pct) begin
            send_sample(ALL_HIGH);
            return;
        end
        send_sample(column_pattern(key[1:0]));
        repeat ($urandom_range(3)) send_sample(4'($urandom_range(14)));
        while (pr_phase != PH_SCAN) begin
            if (pr_phase == PH_HOLD) begin
                send_sample(ALL_HIGH);
            end else begin
                sit_out_wait();
                if ($urandom_range(99) < bounce_pct) send_sample(4'($urandom_range(14)));
                else send_sample(ALL_HIGH);
            end
        end
    endtask

    task automatic test_directed_cases();
        repeat (7) send_sample(ALL_HIGH);    // wrap past the last row
        write_debounce(16'd0);               // zero debounce acts as one
        send_sample(4'h0);                   // all four columns low at row 2
        send_sample(4'h6);                   // several low on recheck: column 0 wins
        send_sample(ALL_HIGH);
        send_sample(ALL_HIGH);               // name of key 8
        send_sample(4'hE);
        send_sample(ALL_HIGH);               // press bounce: back to row 0
        write_debounce(16'd3);
        repeat (4) send_sample(ALL_HIGH);
        send_sample(4'h7);                   // column 3 at row 4
        send_sample(ALL_HIGH);               // ignored during the wait
        send_sample(4'h0);
        send_sample(4'h7);
        send_sample(4'h3);
        send_sample(ALL_HIGH);
        send_sample(4'h8);
        send_sample(ALL_HIGH);
        send_sample(4'h5);                   // release bounce: hold again
        send_sample(ALL_HIGH);
        sit_out_wait();
        send_sample(ALL_HIGH);               // two-character name
    endtask

    task automatic test_sink_hold_off();
        write_debounce(16'd2);
        src_idle_en = 1'b0;
        fork
            hold_off_sink(150);
        join_none
        repeat (12) send_sample(ALL_HIGH);
        press_key(5'd17, 0);
        press_key(5'd6, 0);
        src_idle_en = 1'b1;
    endtask

    task automatic test_longest_debounce();
        write_debounce(16'hFFFF);
        src_idle_en = 1'b0;
        sink_idle_en <= 1'b0;
        while (pr_row != 3'd2) send_sample(ALL_HIGH);
        send_sample(column_pattern(2'd1));
        sit_out_wait();
        send_sample(column_pattern(2'd1));   // latch key 9
        write_debounce(16'd1);
        return_to_scan();
        src_idle_en = 1'b1;
        sink_idle_en <= 1'b1;
    endtask

    task automatic test_random_sequences();
        int stop_at;
        int n;
        int pick;
        stop_at = live_samples + 450;
        n = 0;
        write_debounce(16'd2);
        while (live_samples < stop_at) begin
            pick = $urandom_range(99);
            if (n == 25) begin
                src_idle_en = 1'b0;
                sink_idle_en <= 1'b0;
            end
            if (n == 35) begin
                src_idle_en = 1'b1;
                sink_idle_en <= 1'b1;
            end
            if (n < 20) begin
                press_key(5'(n), 10);
            end else if (pick < 8) begin
                write_debounce(($urandom_range(7) == 0) ? 16'd20 : 16'($urandom_range(5)));
            end else if (pick < 20) begin
                repeat ($urandom_range(1, 6)) send_sample(4'($urandom_range(15)));
                return_to_scan();
            end else begin
                press_key(5'($urandom_range(19)), 15);
            end
            n++;
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_sink_hold_off();
        test_longest_debounce();
        test_random_sequences();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && tick_results_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
